// ===== design/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants for the sector cache tag and clock replacement
// control: payload words, cell flags, group encoder records and FSM states.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Field widths fixed by the payload format.
    localparam int SECTOR_W        = 32;
    localparam int SLOT_W          = 6;

    // Default number of cache slots.
    localparam int DEFAULT_ENTRIES = 64;

    // Cells are grouped for the two-level first-set search.
    localparam int GRP_SIZE        = 8;
    localparam int LOC_W           = $clog2(GRP_SIZE);

    // Request word: one cache access.
    typedef struct packed {
        logic                mode;
        logic [SECTOR_W-1:0] sector;
    } scc_req_t;

    // Response word: outcome of one access.
    typedef struct packed {
        logic                hit;
        logic [SLOT_W-1:0]   slot;
        logic                writeback;
        logic [SECTOR_W-1:0] writeback_sector;
    } scc_rsp_t;

    // One flag per search class, handed from cell to cell inside a group.
    typedef struct packed {
        logic hit;    // valid entry holding the requested sector
        logic empty;  // slot not yet filled
        logic hi;     // accessed mark clear, at or above the clock hand
        logic all;    // accessed mark clear, anywhere
    } scc_chain_t;

    // Per-group result of the first level of the search.
    typedef struct packed {
        scc_chain_t       any;
        logic [LOC_W-1:0] loc_hit;
        logic [LOC_W-1:0] loc_empty;
        logic [LOC_W-1:0] loc_hi;
        logic [LOC_W-1:0] loc_all;
    } scc_grp_t;

    // Outcome of the selection step.
    typedef struct packed {
        logic hit;
        logic fill;
        logic evict;
        logic full_lap;  // every accessed mark was set: the hand went right round
    } scc_dec_t;

    // Update command broadcast to every cell.
    typedef struct packed {
        logic commit;
        logic fill;
        logic write;
        logic evict;
        logic full_lap;
    } scc_cmd_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_SELECT,
        ST_COMMIT
    } scc_state_t;

endpackage

// ===== design/scc_chan_if.sv =====
// ----------------------------------------------------------------------------
// scc_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface scc_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== design/scc_cell.sv =====
// ----------------------------------------------------------------------------
// scc_cell
// One cache slot: tag, valid, dirty and accessed marks. Compares its tag with
// the current sector, passes its search flags to the next cell of its group
// and applies the broadcast update command.
// ----------------------------------------------------------------------------
module scc_cell
    import scc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES,
    parameter int IDX     = 0,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SECTOR_W-1:0] sector,
    input  logic [IDX_W-1:0]    hand,
    input  logic [IDX_W-1:0]    slot,
    input  scc_cmd_t            cmd,
    input  scc_chain_t          chain_in,
    output scc_chain_t          chain_out,
    output scc_chain_t          first,
    output logic                valid,
    output logic                sel_dirty,
    output logic [SECTOR_W-1:0] sel_tag
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [SECTOR_W-1:0] tag_reg,   tag_next;
    logic                valid_reg, valid_next;
    logic                dirty_reg, dirty_next;
    logic                ref_reg,   ref_next;

    scc_chain_t cand;
    logic       self;
    logic       in_lap;

    // Search candidates of this cell; the first one in the group wins.
    always_comb
    begin
        cand.hit   = valid_reg && (tag_reg == sector);
        cand.empty = !valid_reg;
        cand.hi    = !ref_reg && (hand <= MY_IDX);
        cand.all   = !ref_reg;
        first      = cand & ~chain_in;
        chain_out  = cand | chain_in;
    end

    // The hand passes this cell on its way to the victim when the cell lies in
    // the circular range from the hand up to, but not including, the victim.
    always_comb
    begin
        self = (slot == MY_IDX);
        if (cmd.full_lap)
        begin
            in_lap = 1'b1;
        end
        else if (hand <= slot)
        begin
            in_lap = (MY_IDX >= hand) && (MY_IDX < slot);
        end
        else
        begin
            in_lap = (MY_IDX >= hand) || (MY_IDX < slot);
        end
    end

    // Update from the broadcast command.
    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        ref_next   = ref_reg;
        if (cmd.commit)
        begin
            if (self)
            begin
                if (cmd.fill)
                begin
                    tag_next   = sector;
                    valid_next = 1'b1;
                    dirty_next = cmd.write;
                end
                else
                begin
                    dirty_next = dirty_reg | cmd.write;
                end
                ref_next = 1'b1;
            end
            else if (cmd.evict && in_lap)
            begin
                ref_next = 1'b0;
            end
        end
    end

    // Marks are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            dirty_reg <= 1'b0;
            ref_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ref_reg   <= ref_next;
        end
    end

    // The tag is only looked at while the slot is valid.
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    // Valid as is; dirty and tag for the selected slot, zero elsewhere to OR.
    assign valid     = valid_reg;
    assign sel_dirty = self && dirty_reg;
    assign sel_tag   = self ? tag_reg : '0;

endmodule

// ===== design/scc_pick.sv =====
// ----------------------------------------------------------------------------
// scc_pick
// Slot selection: registers the per-group first-set results from the cells,
// picks the winning group for each class, decides hit, fill or eviction and
// holds the clock hand.
// ----------------------------------------------------------------------------
module scc_pick
    import scc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES,
    localparam int IDX_W  = $clog2(ENTRIES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  scc_chain_t       first [ENTRIES],
    input  logic             load_grp,
    input  logic             load_dec,
    input  logic             step_hand,
    output scc_dec_t         dec,
    output logic [IDX_W-1:0] slot,
    output logic [IDX_W-1:0] hand
);

    localparam int NGRP  = (ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
    localparam int PAD_N = NGRP * GRP_SIZE;

    scc_chain_t       first_pad [PAD_N];
    scc_grp_t         grp_reg   [NGRP];
    scc_grp_t         grp_next  [NGRP];
    scc_dec_t         dec_reg,  dec_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic [IDX_W-1:0] hand_reg, hand_next;

    logic             hit_any, empty_any, hi_any, all_any;
    logic [IDX_W-1:0] hit_idx, empty_idx, hi_idx, all_idx;

    // Pad the flag row to whole groups.
    for (genvar i = 0; i < PAD_N; i++)
    begin : g_pad
        if (i < ENTRIES)
        begin : g_real
            assign first_pad[i] = first[i];
        end
        else
        begin : g_zero
            assign first_pad[i] = '0;
        end
    end

    // First level: within a group at most one cell flags each class, so the
    // local position is an OR of the flagged positions.
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++)
            begin
                grp_next[g].any = grp_next[g].any | first_pad[g * GRP_SIZE + j];
                if (first_pad[g * GRP_SIZE + j].hit)
                begin
                    grp_next[g].loc_hit = grp_next[g].loc_hit | LOC_W'(j);
                end
                if (first_pad[g * GRP_SIZE + j].empty)
                begin
                    grp_next[g].loc_empty = grp_next[g].loc_empty | LOC_W'(j);
                end
                if (first_pad[g * GRP_SIZE + j].hi)
                begin
                    grp_next[g].loc_hi = grp_next[g].loc_hi | LOC_W'(j);
                end
                if (first_pad[g * GRP_SIZE + j].all)
                begin
                    grp_next[g].loc_all = grp_next[g].loc_all | LOC_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_grp)
        begin
            grp_reg <= grp_next;
        end
    end

    // Second level: lowest group with a flag wins (scanned downwards so the
    // last assignment is the lowest).
    always_comb
    begin
        hit_any   = 1'b0;
        empty_any = 1'b0;
        hi_any    = 1'b0;
        all_any   = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        hi_idx    = '0;
        all_idx   = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_reg[g].any.hit)
            begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(g * GRP_SIZE + int'(grp_reg[g].loc_hit));
            end
            if (grp_reg[g].any.empty)
            begin
                empty_any = 1'b1;
                empty_idx = IDX_W'(g * GRP_SIZE + int'(grp_reg[g].loc_empty));
            end
            if (grp_reg[g].any.hi)
            begin
                hi_any = 1'b1;
                hi_idx = IDX_W'(g * GRP_SIZE + int'(grp_reg[g].loc_hi));
            end
            if (grp_reg[g].any.all)
            begin
                all_any = 1'b1;
                all_idx = IDX_W'(g * GRP_SIZE + int'(grp_reg[g].loc_all));
            end
        end
    end

    // Decision: hit, else lowest empty slot, else the clock victim. The victim
    // is the first clear mark from the hand onwards, wrapping; if every mark is
    // set the hand goes right round and the victim is the hand's own slot.
    always_comb
    begin
        dec_next.hit      = hit_any;
        dec_next.fill     = !hit_any;
        dec_next.evict    = !hit_any && !empty_any;
        dec_next.full_lap = !hit_any && !empty_any && !hi_any && !all_any;
        if (hit_any)
        begin
            slot_next = hit_idx;
        end
        else if (empty_any)
        begin
            slot_next = empty_idx;
        end
        else if (hi_any)
        begin
            slot_next = hi_idx;
        end
        else if (all_any)
        begin
            slot_next = all_idx;
        end
        else
        begin
            slot_next = hand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_reg <= '0;
        end
        else if (load_dec)
        begin
            dec_reg <= dec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_dec)
        begin
            slot_reg <= slot_next;
        end
    end

    // The hand comes to rest one past the victim.
    always_comb
    begin
        hand_next = hand_reg;
        if (step_hand)
        begin
            hand_next = (slot_reg == IDX_W'(ENTRIES - 1)) ? '0 : slot_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_reg <= '0;
        end
        else
        begin
            hand_reg <= hand_next;
        end
    end

    assign dec  = dec_reg;
    assign slot = slot_reg;
    assign hand = hand_reg;

endmodule

// ===== design/sector_cache_clock_policy_top.sv =====
// ----------------------------------------------------------------------------
// sector_cache_clock_policy_top
// Tag and second-chance clock replacement control for a fully associative
// disk-sector cache, built as a row of slot cells with a shared selector.
//
//   channel | dir | word      | fields
//   --------+-----+-----------+-----------------------------------------------
//   req     | in  | scc_req_t | mode, sector
//   rsp     | out | scc_rsp_t | hit, slot, writeback, writeback_sector
//
// Each access runs through ST_GROUP (cell compare and in-group search),
// ST_SELECT (group select) and ST_COMMIT (commit to the cells and the response
// register). The next access is accepted in the commit cycle, while the last one
// commits, and not before. Reset clears every valid, dirty and accessed mark at
// once and puts the hand at slot zero; no clearing pass is needed. While the
// response register is full and not being taken, the access waits in commit.
// ----------------------------------------------------------------------------
module sector_cache_clock_policy_top
    import scc_pkg::*;
#(
    parameter int ENTRIES = DEFAULT_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    scc_chan_if.sink   req,
    scc_chan_if.source rsp
);

    localparam int IDX_W = $clog2(ENTRIES);

    scc_state_t          state_reg, state_next;
    logic                mode_reg;
    logic [SECTOR_W-1:0] sector_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    scc_rsp_t            rsp_reg, rsp_next;

    logic                req_ready;
    logic                accept;
    logic                out_free;
    logic                load_grp;
    logic                load_dec;
    logic                commit;

    scc_dec_t            dec;
    scc_cmd_t            cmd;
    logic [IDX_W-1:0]    slot;
    logic [IDX_W-1:0]    hand;

    scc_chain_t          chain_in  [ENTRIES];
    scc_chain_t          chain_out [ENTRIES];
    scc_chain_t          first     [ENTRIES];
    logic [ENTRIES-1:0]  valid_vec;
    logic [ENTRIES-1:0]  dirty_vec;
    logic [SECTOR_W-1:0] tag_vec   [ENTRIES];
    logic                wb_dirty;
    logic [SECTOR_W-1:0] wb_tag;

    // Sequencer: next state and strobes.
    always_comb
    begin
        out_free   = !rsp_valid_reg || rsp.ready;
        req_ready  = 1'b0;
        load_grp   = 1'b0;
        load_dec   = 1'b0;
        commit     = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req.valid)
                begin
                    state_next = ST_GROUP;
                end
            end
            ST_GROUP:
            begin
                load_grp   = 1'b1;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                load_dec   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    req_ready  = 1'b1;
                    state_next = req.valid ? ST_GROUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req.ready = req_ready;
    assign accept    = req.valid && req_ready;

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= req.data.mode;
            sector_reg <= req.data.sector;
        end
    end

    // Update command shared by all cells.
    always_comb
    begin
        cmd.commit   = commit;
        cmd.fill     = dec.fill;
        cmd.write    = mode_reg;
        cmd.evict    = dec.evict;
        cmd.full_lap = dec.full_lap;
    end

    // Row of slot cells; search flags ripple within each group.
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        if (i % GRP_SIZE == 0)
        begin : g_head
            assign chain_in[i] = '0;
        end
        else
        begin : g_link
            assign chain_in[i] = chain_out[i-1];
        end

        scc_cell #(
            .ENTRIES (ENTRIES),
            .IDX     (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .sector    (sector_reg),
            .hand      (hand),
            .slot      (slot),
            .cmd       (cmd),
            .chain_in  (chain_in[i]),
            .chain_out (chain_out[i]),
            .first     (first[i]),
            .valid     (valid_vec[i]),
            .sel_dirty (dirty_vec[i]),
            .sel_tag   (tag_vec[i])
        );
    end

    scc_pick #(
        .ENTRIES (ENTRIES)
    ) u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .first     (first),
        .load_grp  (load_grp),
        .load_dec  (load_dec),
        .step_hand (commit && dec.evict),
        .dec       (dec),
        .slot      (slot),
        .hand      (hand)
    );

    // Old tag and dirty mark of the selected slot; only that cell drives.
    always_comb
    begin
        wb_dirty = |dirty_vec;
        wb_tag   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            wb_tag = wb_tag | tag_vec[i];
        end
    end

    // Response register.
    always_comb
    begin
        rsp_next.hit              = dec.hit;
        rsp_next.slot             = SLOT_W'(slot);
        rsp_next.writeback        = dec.evict && wb_dirty;
        rsp_next.writeback_sector = (dec.evict && wb_dirty) ? wb_tag : '0;
        rsp_valid_next            = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // A fill into an empty slot must really find that slot empty.
    a_fill_empty: assert property (@(posedge clk) disable iff (!rst_n)
        commit && dec.fill && !dec.evict |-> !valid_vec[slot])
        else $error("fill chose a slot that is already valid");

    // A hit must point at a valid slot.
    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        commit && dec.hit |-> valid_vec[slot])
        else $error("hit reported on an invalid slot");

    // The hand moves only when a victim is evicted.
    a_hand_still: assert property (@(posedge clk) disable iff (!rst_n)
        !(commit && dec.evict) |=> $stable(hand))
        else $error("clock hand moved without an eviction");

    // An accepted access always starts its search in the next cycle.
    a_accept_group: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_GROUP)
        else $error("accepted access did not enter the search");

endmodule
